[hdl/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, switched off while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

[hdl/sapq_pkg.sv]
// Package: types and constants of the sorted-array priority queue.
`timescale 1ns / 1ps
package sapq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                      command;
        logic signed [DATA_W-1:0]  item_value;
    } t_sapq_in;

    typedef struct packed {
        logic signed [DATA_W-1:0]  removed_value;
        t_status                   status;
        logic [OCC_W-1:0]          occupancy;
    } t_sapq_out;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [DATA_W-1:0]  value;
    } t_sapq_ctl;

endpackage

[hdl/sapq_cell.sv]
// One storage cell of the sorted chain: holds one entry, talks to both neighbours.
`timescale 1ns / 1ps
module sapq_cell import sapq_pkg::*; (
    input  logic                      i_clk,
    input  t_sapq_ctl                 i_ctl,
    input  logic                      i_occupied,
    input  logic signed [DATA_W-1:0]  i_prev_value,
    input  logic                      i_prev_gt,
    input  logic signed [DATA_W-1:0]  i_next_value,
    output logic signed [DATA_W-1:0]  o_value,
    output logic                      o_gt
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    // Entry is strictly greater than the new value: it moves one place back.
    assign o_gt    = i_occupied && (r_value > i_ctl.value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (i_prev_gt) begin
                n_value = i_prev_value;
            end else if (o_gt || !i_occupied) begin
                n_value = i_ctl.value;
            end
        end else if (i_ctl.rem) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

[hdl/sorted_array_priority_queue.sv]
// Sorted-array minimum priority queue: top level with the cell chain and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one command per transfer:
//   insert item_value, or remove the smallest stored value.
//   Output channel (o_out_valid / i_out_stall / o_out) returns exactly one result
//   per accepted command: removed value (-1 unless a remove succeeded), status
//   (ok, insert dropped as full, remove on empty) and occupancy after the command.
//   The result is registered and is valid in the cycle after the command is accepted.
//   Throughput: one command per cycle while o_in_stall is low; every cell compares
//   its entry with the incoming value in parallel and shifts in the same edge, so
//   no item waits on the previous one.
//   Equal values leave in arrival order.
//   Reset (i_rst_n low, synchronous) empties the queue and drops any pending
//   result; stored entries are not cleared, only the occupancy count.
//   When the receiver stalls with a result pending, o_in_stall rises and the
//   next command waits; the held result stays unchanged until transferred.
`timescale 1ns / 1ps
module sorted_array_priority_queue import sapq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_sapq_in   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_sapq_out  o_out
);

    // Occupancy count and result register
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    t_sapq_out        r_out;
    t_sapq_out        n_out;

    logic             in_acc;
    logic             full;
    logic             empty;
    t_sapq_ctl        ctl;

    // Chain wiring: gt[i] comes out of cell i-1, gt[0] ties low
    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic                     gt         [DEPTH+1];
    logic [OCC_W+CNT_W-1:0]   occ_ext;

    // A result only blocks the input while it is held by the receiver
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    assign ctl.ins   = in_acc && (i_in.command == CMD_INSERT) && !full;
    assign ctl.rem   = in_acc && (i_in.command == CMD_REMOVE) && !empty;
    assign ctl.value = i_in.item_value;

    assign gt[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] prev_value;
        logic signed [DATA_W-1:0] next_value;

        if (g == 0) begin : g_first
            assign prev_value = '0;
        end else begin : g_mid
            assign prev_value = cell_value[g-1];
        end

        // Last cell keeps its own value on a remove
        if (g == DEPTH - 1) begin : g_last
            assign next_value = cell_value[g];
        end else begin : g_body
            assign next_value = cell_value[g+1];
        end

        sapq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (r_count > CNT_W'(g)),
            .i_prev_value (prev_value),
            .i_prev_gt    (gt[g]),
            .i_next_value (next_value),
            .o_value      (cell_value[g]),
            .o_gt         (gt[g+1])
        );
    end

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Occupancy is cut to its 5-bit field; counts up to DEPTH fit without wrapping
    assign occ_ext = {{OCC_W{1'b0}}, n_count};

    always_comb begin
        n_out               = r_out;
        n_out.removed_value = '1;
        n_out.status        = ST_OK;
        n_out.occupancy     = occ_ext[OCC_W-1:0];
        if (in_acc) begin
            if (i_in.command == CMD_INSERT) begin
                if (full) begin
                    n_out.status = ST_FULL;
                end
            end else begin
                if (empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.removed_value = cell_value[0];
                end
            end
        end else begin
            n_out = r_out;
        end
    end

    always_comb begin
        if (in_acc) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[hdl/sapq_checker.sv]
// Port-level checker for the sorted-array priority queue, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sapq_assertions import sapq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       o_in_stall,
    input  t_sapq_in   i_in,
    input  logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_sapq_out  o_out
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // Held result does not change
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out), "result changed while stalled")

    // Every accepted command gives a result on the next cycle
    `ASSERT_CLK(a_one_result, i_clk, i_rst_n, in_acc |=> o_out_valid, "accepted command gave no result")

    // A fresh result only follows an accepted command
    `ASSERT_CLK(a_no_spurious, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(in_acc), "result without command")

    // Dropped insert means the queue is at capacity
    `ASSERT_IMPL(a_full_occ, i_clk, i_rst_n, o_out_valid && o_out.status == ST_FULL, o_out.occupancy == OCC_W'(DEPTH), "full flag with wrong occupancy")

    // Remove on empty leaves it empty and returns minus one
    `ASSERT_IMPL(a_empty_res, i_clk, i_rst_n, o_out_valid && o_out.status == ST_EMPTY, o_out.occupancy == '0 && o_out.removed_value == -32'sd1, "bad empty result")

endmodule

bind sorted_array_priority_queue sapq_assertions u_sapq_assertions (.*);
